// File: hw/rtl/knnc_pkg.sv
package knnc_pkg;

    // Fixed widths of the interface fields
    localparam int LABEL_W    = 8;
    localparam int K_W        = 5;
    localparam int PRED_W     = 2;
    localparam int DIST_W     = 39;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_FEATURES  = 16;
    localparam int DEF_MAX_NEIGHBORS = 16;
    localparam int DEF_VALUE_WIDTH   = 16;

    localparam logic [K_W-1:0] K_RESET = K_W'(3);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [REG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'b0;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [PRED_W-1:0] PRED_ZERO = 2'd0;
    localparam logic [PRED_W-1:0] PRED_ONE  = 2'd1;
    localparam logic [PRED_W-1:0] PRED_TIE  = 2'd2;

    typedef struct packed {
        logic               do_clear;
        logic               do_insert;
        logic               do_vote;
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
    } cmd_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_VOTE
    } back_state_t;

endpackage

// File: hw/rtl/knn_binary_classifier.sv
// Throughput: one feature request per cycle while the command queue accepts pushes; a sample's
// closing feature can cost the back end a sorted-list insert, and the vote drains min(kept, k) labels.
// After the last sample's final feature is accepted, the result passes through the two front
// stages, the command queue and the vote sequencer.
// Reset (aresetn, synchronous, active low) clears the control state and sets k to 3;
// the query memory and the neighbor list keep their contents until written.
module knn_binary_classifier
    import knnc_pkg::*;
#(
    parameter int MAX_FEATURES  = DEF_MAX_FEATURES,
    parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic signed [VALUE_WIDTH-1:0]       s_feature_value,
    input  logic [LABEL_W-1:0]                  s_class_label,
    input  logic                                s_last_feature,
    input  logic                                s_last_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [PRED_W-1:0]                   m_prediction,
    output logic [$clog2(MAX_NEIGHBORS+1)-1:0]  m_zero_votes,
    output logic [$clog2(MAX_NEIGHBORS+1)-1:0]  m_one_votes,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_ADDR_W-1:0]               paddr,
    input  logic [APB_DATA_W-1:0]               pwdata,
    output logic [APB_DATA_W-1:0]               prdata,
    output logic                                pready
);

    logic [K_W-1:0] k_reg, k_next;
    logic           reg_hit;

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_NEIGHBOR_COUNT;

    always_comb begin
        k_next = k_reg;
        if (psel && penable && pwrite && pready && reg_hit) begin
            k_next = pwdata[K_W-1:0];
        end
        prdata = '0;
        if (reg_hit) begin
            prdata = APB_DATA_W'(k_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= K_RESET;
        end else begin
            k_reg <= k_next;
        end
    end

    knnc_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_feature_value (s_feature_value),
        .s_class_label   (s_class_label),
        .s_last_feature  (s_last_feature),
        .s_last_sample   (s_last_sample),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_cmd        (push_cmd)
    );

    knnc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    knnc_back #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_cmd        (pop_cmd),
        .neighbor_count (k_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prediction   (m_prediction),
        .m_zero_votes   (m_zero_votes),
        .m_one_votes    (m_one_votes)
    );

endmodule

// File: hw/rtl/knnc_front.sv
module knnc_front
    import knnc_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic signed [VALUE_WIDTH-1:0] s_feature_value,
    input  logic [LABEL_W-1:0]            s_class_label,
    input  logic                          s_last_feature,
    input  logic                          s_last_sample,
    output logic                          push_valid,
    input  logic                          push_ready,
    output cmd_t                          push_cmd
);

    localparam int VW    = VALUE_WIDTH;
    localparam int POS_W = $clog2(MAX_FEATURES + 1);
    localparam int ADR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    logic [VW-1:0] qmem [MAX_FEATURES];

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accept, en, in_range;

    // stage B
    logic               b_valid_reg, b_op_reg, b_range_reg, b_lastf_reg, b_lasts_reg;
    logic [LABEL_W-1:0] b_label_reg;
    logic [VW-1:0]      b_feat_reg, q_rd_reg;

    // stage C
    logic               c_valid_reg, c_op_reg, c_range_reg, c_lastf_reg, c_lasts_reg;
    logic               c_eq_reg;
    logic [LABEL_W-1:0] c_label_reg;
    logic [2*VW-1:0]    c_sq_reg;

    // per-vector accumulation
    logic [DIST_W-1:0]  dsum_reg, dsum_next;
    logic               same_reg, same_next;
    logic [LABEL_W-1:0] qlabel_reg, qlabel_next;

    logic [VW:0]        diff, mag;
    logic [VW-1:0]      absd;
    logic [2*VW-1:0]    prod;
    logic [63:0]        prod_wide;
    logic [DIST_W-1:0]  sq_sat, dsum_upd;
    logic [DIST_W:0]    sum;
    logic               samp, contrib, same_upd, same_fin, push_need;

    assign in_range = pos_reg < POS_W'(MAX_FEATURES);
    assign s_ready  = en;
    assign accept   = s_valid && s_ready;

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (s_last_feature) begin
                pos_next = '0;
            end else if (in_range) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_operation == OP_QUERY && in_range) begin
            qmem[pos_reg[ADR_W-1:0]] <= s_feature_value;
        end
        if (en) begin
            q_rd_reg <= qmem[pos_reg[ADR_W-1:0]];
        end
    end

    // stage B: difference and square
    always_comb begin
        diff = {b_feat_reg[VW-1], b_feat_reg} - {q_rd_reg[VW-1], q_rd_reg};
        mag  = diff[VW] ? (~diff + 1'b1) : diff;
        absd = mag[VW-1:0];
        prod = (2*VW)'(absd) * (2*VW)'(absd);
    end

    // stage C: saturating accumulate and command build
    always_comb begin
        prod_wide = 64'(c_sq_reg);
        sq_sat    = (prod_wide > 64'(DIST_MAX)) ? DIST_MAX : prod_wide[DIST_W-1:0];
        sum       = {1'b0, dsum_reg} + {1'b0, sq_sat};
        samp      = c_op_reg == OP_SAMPLE;
        contrib   = samp && c_range_reg;
        dsum_upd  = contrib ? (sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0]) : dsum_reg;
        same_upd  = same_reg && !(contrib && !c_eq_reg);
        same_fin  = same_upd && (c_label_reg == qlabel_reg);

        push_cmd.do_clear  = !samp;
        push_cmd.do_insert = samp && !same_fin;
        push_cmd.do_vote   = samp && c_lasts_reg;
        push_cmd.distance  = dsum_upd;
        push_cmd.label     = c_label_reg;

        push_need  = c_lastf_reg && (!samp || !same_fin || c_lasts_reg);
        push_valid = c_valid_reg && push_need;
        en         = !(push_valid && !push_ready);

        dsum_next   = dsum_reg;
        same_next   = same_reg;
        qlabel_next = qlabel_reg;
        if (c_valid_reg && en) begin
            if (c_lastf_reg) begin
                dsum_next = '0;
                same_next = 1'b1;
                if (!samp) begin
                    qlabel_next = c_label_reg;
                end
            end else begin
                dsum_next = dsum_upd;
                same_next = same_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            dsum_reg    <= '0;
            same_reg    <= 1'b1;
            qlabel_reg  <= '0;
        end else begin
            pos_reg    <= pos_next;
            dsum_reg   <= dsum_next;
            same_reg   <= same_next;
            qlabel_reg <= qlabel_next;
            if (en) begin
                b_valid_reg <= accept;
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_op_reg    <= s_operation;
            b_range_reg <= in_range;
            b_lastf_reg <= s_last_feature;
            b_lasts_reg <= s_last_sample;
            b_label_reg <= s_class_label;
            b_feat_reg  <= s_feature_value;

            c_op_reg    <= b_op_reg;
            c_range_reg <= b_range_reg;
            c_lastf_reg <= b_lastf_reg;
            c_lasts_reg <= b_lasts_reg;
            c_label_reg <= b_label_reg;
            c_eq_reg    <= b_feat_reg == q_rd_reg;
            c_sq_reg    <= prod;
        end
    end

endmodule

// File: hw/rtl/knnc_queue.sv
module knnc_queue
    import knnc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t entry_reg [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/knnc_back.sv
module knnc_back
    import knnc_pkg::*;
#(
    parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  cmd_t                                   pop_cmd,
    input  logic [K_W-1:0]                         neighbor_count,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [PRED_W-1:0]                      m_prediction,
    output logic [$clog2(MAX_NEIGHBORS+1)-1:0]     m_zero_votes,
    output logic [$clog2(MAX_NEIGHBORS+1)-1:0]     m_one_votes
);

    localparam int NB    = MAX_NEIGHBORS;
    localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);

    logic [DIST_W-1:0]  best_dist_reg  [NB];
    logic [LABEL_W-1:0] best_label_reg [NB];
    logic [DIST_W-1:0]  prev_dist  [NB];
    logic [LABEL_W-1:0] prev_label [NB];
    logic [LABEL_W-1:0] next_label [NB];

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0] kept_reg, kept_next, kept_after;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [CNT_W-1:0] zeros_reg, zeros_next, ones_reg, ones_next;
    logic [CNT_W-1:0] k_eff;

    logic              m_valid_reg, m_valid_next;
    logic [PRED_W-1:0] pred_reg, pred_next;
    logic [CNT_W-1:0]  out_zero_reg, out_zero_next, out_one_reg, out_one_next;

    logic [NB-1:0] le_vec, new_vec, shift_vec;
    logic          pop, ins_en, vote_shift, out_load;

    assign m_valid      = m_valid_reg;
    assign m_prediction = pred_reg;
    assign m_zero_votes = out_zero_reg;
    assign m_one_votes  = out_one_reg;

    assign k_eff = (int'(neighbor_count) > NB) ? CNT_W'(NB) : CNT_W'(neighbor_count);

    for (genvar g = 0; g < NB; g++) begin : g_link
        if (g == 0) begin : g_head
            assign prev_dist[g]  = '0;
            assign prev_label[g] = '0;
        end else begin : g_body
            assign prev_dist[g]  = best_dist_reg[g-1];
            assign prev_label[g] = best_label_reg[g-1];
        end
        if (g == NB - 1) begin : g_tail
            assign next_label[g] = '0;
        end else begin : g_mid
            assign next_label[g] = best_label_reg[g+1];
        end
    end

    // Each cell of the sorted list decides locally: keep, take the new entry, or shift down
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            le_vec[i] = (CNT_W'(i) < kept_reg) && !(best_dist_reg[i] > pop_cmd.distance);
        end
        for (int i = 0; i < NB; i++) begin
            if (i == 0) begin
                new_vec[i]   = !le_vec[i];
                shift_vec[i] = 1'b0;
            end else begin
                new_vec[i]   = !le_vec[i] && le_vec[i-1];
                shift_vec[i] = !le_vec[i] && !le_vec[i-1] && (CNT_W'(i) <= kept_reg);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        kept_next     = kept_reg;
        remain_next   = remain_reg;
        zeros_next    = zeros_reg;
        ones_next     = ones_reg;
        pop_ready     = 1'b0;
        ins_en        = 1'b0;
        vote_shift    = 1'b0;
        out_load      = 1'b0;
        pred_next     = pred_reg;
        out_zero_next = out_zero_reg;
        out_one_next  = out_one_reg;
        kept_after    = kept_reg;

        if (pop_cmd.do_clear) begin
            kept_after = '0;
        end else if (pop_cmd.do_insert && kept_reg < CNT_W'(NB)) begin
            kept_after = kept_reg + 1'b1;
        end

        unique case (state_reg)
            BACK_IDLE: begin
                // a vote request waits until the result register is free
                pop_ready = !pop_cmd.do_vote || !m_valid_reg;
                pop       = pop_valid && pop_ready;
                if (pop) begin
                    ins_en    = pop_cmd.do_insert;
                    kept_next = kept_after;
                    if (pop_cmd.do_vote) begin
                        remain_next = (kept_after < k_eff) ? kept_after : k_eff;
                        zeros_next  = '0;
                        ones_next   = '0;
                        state_next  = BACK_VOTE;
                    end
                end
            end
            BACK_VOTE: begin
                pop = 1'b0;
                if (remain_reg == '0) begin
                    out_load      = 1'b1;
                    out_zero_next = zeros_reg;
                    out_one_next  = ones_reg;
                    if (zeros_reg > ones_reg) begin
                        pred_next = PRED_ZERO;
                    end else if (ones_reg > zeros_reg) begin
                        pred_next = PRED_ONE;
                    end else begin
                        pred_next = PRED_TIE;
                    end
                    kept_next  = '0;
                    state_next = BACK_IDLE;
                end else begin
                    // labels drain through the head cell, one voter per cycle
                    vote_shift  = 1'b1;
                    remain_next = remain_reg - 1'b1;
                    if (best_label_reg[0] == LABEL_W'(0)) begin
                        zeros_next = zeros_reg + 1'b1;
                    end else if (best_label_reg[0] == LABEL_W'(1)) begin
                        ones_next = ones_reg + 1'b1;
                    end
                end
            end
            default: begin
                pop        = 1'b0;
                state_next = BACK_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NB; i++) begin
            if (ins_en) begin
                if (new_vec[i]) begin
                    best_dist_reg[i]  <= pop_cmd.distance;
                    best_label_reg[i] <= pop_cmd.label;
                end else if (shift_vec[i]) begin
                    best_dist_reg[i]  <= prev_dist[i];
                    best_label_reg[i] <= prev_label[i];
                end
            end else if (vote_shift) begin
                best_label_reg[i] <= next_label[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BACK_IDLE;
            kept_reg    <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            kept_reg    <= kept_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        zeros_reg    <= zeros_next;
        ones_reg     <= ones_next;
        pred_reg     <= pred_next;
        out_zero_reg <= out_zero_next;
        out_one_reg  <= out_one_next;
    end

endmodule

// File: hw/rtl/knnc_checker.sv
module knnc_checker
    import knnc_pkg::*;
#(
    parameter int VOTE_W = $clog2(DEF_MAX_NEIGHBORS + 1)
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [PRED_W-1:0] m_prediction,
    input logic [VOTE_W-1:0] m_zero_votes,
    input logic [VOTE_W-1:0] m_one_votes
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prediction)
            && $stable(m_zero_votes) && $stable(m_one_votes))
        else $error("result changed while stalled");

    a_pred_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_prediction == PRED_ZERO |-> m_zero_votes > m_one_votes)
        else $error("class zero without a zero majority");

    a_pred_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_prediction == PRED_ONE |-> m_one_votes > m_zero_votes)
        else $error("class one without a one majority");

    a_pred_tie: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_prediction == PRED_TIE) == (m_zero_votes == m_one_votes))
        else $error("tie flag disagrees with vote counts");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind knn_binary_classifier knnc_checker #(
    .VOTE_W ($clog2(MAX_NEIGHBORS + 1))
) u_knnc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_prediction (m_prediction),
    .m_zero_votes (m_zero_votes),
    .m_one_votes  (m_one_votes)
);

// File: sim/tb_knn_binary_classifier.sv
module tb_knn_binary_classifier;
    import knnc_pkg::*;

    localparam int NFEAT   = DEF_MAX_FEATURES;
    localparam int NNEAR   = DEF_MAX_NEIGHBORS;
    localparam int VAL_W   = DEF_VALUE_WIDTH;
    localparam int VOTE_W  = $clog2(DEF_MAX_NEIGHBORS + 1);
    localparam int SETTLE  = 40;
    localparam int N_ITEMS = 1500;
    localparam int N_PHASE = 8;

    localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        logic               op;
        logic [VAL_W-1:0]   val;
        logic [LABEL_W-1:0] label;
        logic               lf;
        logic               ls;
    } feat_req_t;

    localparam int REQ_W = $bits(feat_req_t);

    typedef struct packed {
        logic [PRED_W-1:0] pred;
        logic [VOTE_W-1:0] zeros;
        logic [VOTE_W-1:0] ones;
    } vote_t;

    typedef struct packed {
        feat_req_t req;
        logic      pinned;
        vote_t     vote;
    } stim_row_t;

    // query label 7 over (7FFF, 8000, 0000); later query label 1 over (FFFF)
    localparam stim_row_t DIRECTED [19] = '{
        '{'{OP_QUERY,  16'h7FFF, 8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_QUERY,  16'h8000, 8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_QUERY,  16'h0000, 8'd7,   1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'h7FFF, 8'd0,   1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'h8000, 8'd0,   1'b0, 1'b0}, 1'b0, '0},
        // copy of the query is skipped: empty vote
        '{'{OP_SAMPLE, 16'h0000, 8'd7,   1'b1, 1'b1}, 1'b1, '{PRED_TIE, 5'd0, 5'd0}},
        '{'{OP_SAMPLE, 16'h8000, 8'd1,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'h7FFF, 8'd1,   1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'h7FFF, 8'd0,   1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'h7FFF, 8'd255, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'h0001, 8'd1,   1'b1, 1'b1}, 1'b0, '0},
        // query feature in the middle of a sample
        '{'{OP_SAMPLE, 16'h0064, 8'd0,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_QUERY,  16'h00C8, 8'd3,   1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'hFFFF, 8'd0,   1'b1, 1'b1}, 1'b1, '{PRED_ZERO, 5'd1, 5'd0}},
        '{'{OP_QUERY,  16'hFFFF, 8'd1,   1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'hFFFF, 8'd1,   1'b1, 1'b1}, 1'b1, '{PRED_TIE, 5'd0, 5'd0}},
        '{'{OP_SAMPLE, 16'h5555, 8'd0,   1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'hAAAA, 8'd1,   1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_SAMPLE, 16'h0000, 8'd2,   1'b1, 1'b1}, 1'b0, '0}
    };

    localparam logic [K_W-1:0] K_PLAN [N_PHASE] = '{
        5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd2, 5'd8
    };

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic                     s_operation     = OP_QUERY;
    logic signed [VAL_W-1:0]  s_feature_value = '0;
    logic [LABEL_W-1:0]       s_class_label   = '0;
    logic                     s_last_feature  = 1'b0;
    logic                     s_last_sample   = 1'b0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [PRED_W-1:0]        m_prediction;
    logic [VOTE_W-1:0]        m_zero_votes;
    logic [VOTE_W-1:0]        m_one_votes;
    logic                     psel            = 1'b0;
    logic                     penable         = 1'b0;
    logic                     pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr           = '0;
    logic [APB_DATA_W-1:0]    pwdata          = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    knn_binary_classifier dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_feature_value (s_feature_value),
        .s_class_label   (s_class_label),
        .s_last_feature  (s_last_feature),
        .s_last_sample   (s_last_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prediction    (m_prediction),
        .m_zero_votes    (m_zero_votes),
        .m_one_votes     (m_one_votes),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // classifier state as the testbench sees it
    logic signed [VAL_W-1:0] qry_feat [NFEAT];
    logic [NFEAT-1:0]        qry_written;
    logic [LABEL_W-1:0]      qry_label;
    int                      feat_pos;
    logic [DIST_W-1:0]       dist_acc;
    bit                      match_q;
    logic [DIST_W-1:0]       near_dist [NNEAR];
    logic [LABEL_W-1:0]      near_label [NNEAR];
    int                      near_cnt;
    logic [K_W-1:0]          k_reg;

    vote_t pending_votes [$];
    int    err_cnt    = 0;
    int    items_sent = 0;
    int    sink_stall = 0;
    bit    src_calm   = 1'b0;
    bit    sink_calm  = 1'b0;

    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_cnt++;
    endtask

    function automatic void restart_sample();
        feat_pos = 0;
        dist_acc = '0;
        match_q  = 1'b1;
    endfunction

    function automatic logic [DIST_W-1:0] sq_term(logic signed [VAL_W-1:0] a,
                                                  logic signed [VAL_W-1:0] b);
        longint d;
        longint unsigned sq;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        sq = longint'(d * d);
        return (sq > 64'(DIST_MAX)) ? DIST_MAX : sq[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    // sorted insert; ties go behind the entries already kept
    function automatic void keep_nearest(logic [DIST_W-1:0] d, logic [LABEL_W-1:0] lbl);
        int slot;
        int i;
        slot = near_cnt;
        while (slot > 0 && near_dist[slot-1] > d) slot--;
        if (slot >= NNEAR) return;
        i = (near_cnt < NNEAR) ? near_cnt : NNEAR - 1;
        while (i > slot) begin
            near_dist[i]  = near_dist[i-1];
            near_label[i] = near_label[i-1];
            i--;
        end
        near_dist[slot]  = d;
        near_label[slot] = lbl;
        if (near_cnt < NNEAR) near_cnt++;
    endfunction

    function automatic bit knn_predict(feat_req_t r, output vote_t v);
        int p;
        int kk;
        int voters;
        int zeros;
        int ones;
        int i;
        logic signed [VAL_W-1:0] fv;
        p  = feat_pos;
        fv = r.val;
        v  = '0;
        if (r.op == OP_QUERY) begin
            if (p < NFEAT) begin
                qry_feat[p]    = fv;
                qry_written[p] = 1'b1;
                feat_pos       = p + 1;
            end
            if (r.lf) begin
                qry_label = r.label;
                near_cnt  = 0;
                restart_sample();
            end
            return 1'b0;
        end
        if (p < NFEAT) begin
            dist_acc = sat_sum(dist_acc, sq_term(fv, qry_feat[p]));
            if (fv != qry_feat[p]) match_q = 1'b0;
            feat_pos = p + 1;
        end
        if (!r.lf) return 1'b0;
        if (r.label != qry_label) match_q = 1'b0;
        if (!match_q) keep_nearest(dist_acc, r.label);
        restart_sample();
        if (!r.ls) return 1'b0;
        kk     = (k_reg > NNEAR) ? NNEAR : int'(k_reg);
        voters = (near_cnt < kk) ? near_cnt : kk;
        zeros  = 0;
        ones   = 0;
        for (i = 0; i < voters; i++) begin
            if (near_label[i] == 0) zeros++;
            else if (near_label[i] == 1) ones++;
        end
        v.pred  = (zeros > ones) ? PRED_ZERO : (ones > zeros) ? PRED_ONE : PRED_TIE;
        v.zeros = VOTE_W'(zeros);
        v.ones  = VOTE_W'(ones);
        near_cnt = 0;
        return 1'b1;
    endfunction

    function automatic int written_run();
        int n;
        n = 0;
        while (n < NFEAT && qry_written[n]) n++;
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            case ($urandom_range(0, 4))
                0: return VMIN;
                1: return VMAX;
                2: return '0;
                3: return '1;
                default: return VAL_W'(1);
            endcase
        end
        if (r < 6) return VAL_W'($urandom_range(0, 1024) - 512);
        return VAL_W'($urandom);
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return '0;
        if (r < 18) return LABEL_W'(1);
        return LABEL_W'($urandom);
    endfunction

    task automatic send_req(feat_req_t r, bit pinned, vote_t pinned_vote);
        vote_t v;
        int    gap;
        // never let a sample read a query slot that was never loaded
        if (r.op == OP_SAMPLE && feat_pos < NFEAT && !qry_written[feat_pos]) r.op = OP_QUERY;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= r.op;
        s_feature_value <= r.val;
        s_class_label   <= r.label;
        s_last_feature  <= r.lf;
        s_last_sample   <= r.ls;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (knn_predict(r, v))
            pending_votes.insert(pending_votes.size(), pinned ? pinned_vote : v);
    endtask

    task automatic apb_access(bit wr, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(4 * REG_NEIGHBOR_COUNT);
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_neighbors(logic [K_W-1:0] k);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, APB_DATA_W'(k), rd);
        k_reg = k;
        @(posedge aclk);
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(k))
            report_mismatch($sformatf("neighbor_count read %0d, wrote %0d", rd, k));
    endtask

    // drain all votes, then give the back end time to finish a trailing insert
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_votes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // one query vector, a run of samples, usually closed by a vote
    task automatic run_episode();
        int        lq;
        int        nsamp;
        int        slen;
        int        maxlen;
        int        run;
        int        i;
        int        j;
        int        r;
        bit        twin;
        bit        vote_at_end;
        logic [LABEL_W-1:0] lbl;
        feat_req_t req;
        vote_t     none;
        none = '0;
        lq  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, NFEAT + 2);
        lbl = pick_label();
        for (i = 0; i < lq; i++) begin
            req.op    = OP_QUERY;
            req.val   = pick_value();
            req.label = (i == lq - 1) ? lbl : LABEL_W'($urandom);
            req.lf    = (i == lq - 1);
            req.ls    = ($urandom_range(0, 7) == 0);
            send_req(req, 1'b0, none);
        end
        run    = written_run();
        maxlen = (run == NFEAT) ? NFEAT + 2 : run;
        r      = $urandom_range(0, 9);
        nsamp  = (r < 7) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(7, 16)
                                                         : $urandom_range(17, 24);
        if (maxlen == 0) nsamp = 0;
        vote_at_end = ($urandom_range(0, 9) != 0);
        for (j = 0; j < nsamp; j++) begin
            twin = ($urandom_range(0, 9) == 0);
            slen = ($urandom_range(0, 3) != 0) ? $urandom_range(1, (maxlen < 4) ? maxlen : 4)
                                               : $urandom_range(1, maxlen);
            lbl  = twin ? qry_label : pick_label();
            for (i = 0; i < slen; i++) begin
                req.op = OP_SAMPLE;
                if (feat_pos < NFEAT && (twin || $urandom_range(0, 4) < 2))
                    req.val = qry_feat[feat_pos];
                else
                    req.val = pick_value();
                req.lf    = (i == slen - 1);
                req.label = req.lf ? lbl : LABEL_W'($urandom);
                req.ls    = (req.lf && j == nsamp - 1) ? vote_at_end
                                                       : ($urandom_range(0, 9) == 0);
                send_req(req, 1'b0, none);
            end
        end
        // occasional junk requests between episodes
        if ($urandom_range(0, 4) == 0) begin
            r = $urandom_range(1, 6);
            for (i = 0; i < r; i++) begin
                req = REQ_W'($urandom);
                send_req(req, 1'b0, none);
            end
        end
    endtask

    always @(posedge aclk) begin : result_sink
        vote_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_votes.size() == 0) begin
                report_mismatch($sformatf("vote with none pending: pred %0d zeros %0d ones %0d",
                                          m_prediction, m_zero_votes, m_one_votes));
            end else begin
                want = pending_votes.pop_front();
                if (m_prediction !== want.pred)
                    report_mismatch($sformatf("prediction %0d, expected %0d",
                                              m_prediction, want.pred));
                if (m_zero_votes !== want.zeros)
                    report_mismatch($sformatf("zero_votes %0d, expected %0d",
                                              m_zero_votes, want.zeros));
                if (m_one_votes !== want.ones)
                    report_mismatch($sformatf("one_votes %0d, expected %0d",
                                              m_one_votes, want.ones));
            end
        end
        if (sink_stall > 0) begin
            m_ready <= 1'b0;
            sink_stall--;
        end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            sink_stall = pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [APB_DATA_W-1:0] rd;
        int i;
        int ph;
        int target;
        k_reg       = K_RESET;
        qry_written = '0;
        qry_label   = '0;
        near_cnt    = 0;
        restart_sample();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(K_RESET))
            report_mismatch($sformatf("neighbor_count after reset %0d", rd));

        for (i = 0; i < $size(DIRECTED); i++)
            send_req(DIRECTED[i].req, DIRECTED[i].pinned, DIRECTED[i].vote);
        settle();

        for (ph = 0; ph < N_PHASE; ph++) begin
            set_neighbors(K_PLAN[ph]);
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            target    = items_sent + N_ITEMS / N_PHASE;
            while (items_sent < target) run_episode();
            settle();
        end

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
